// ----- sv/fsd_pkg.sv -----
// Footswitch channel decoder package: selection modes, command codes,
// result and tick-record types and result builders. No dependencies.
`default_nettype none

package fsd_pkg;

   localparam int MAX_RESULTS = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [7:0] GUARD_RESET = 8'd50;
   localparam logic [1:0] ZIG_HIGH_RESET = 2'd2;

   localparam logic CSR_SWITCH_MODE = 1'b0;
   localparam logic CSR_GUARD_TICKS = 1'b1;

   typedef enum logic [1:0] {
      MODE_DISCRETE = 2'd0,
      MODE_RELAY    = 2'd1,
      MODE_RING     = 2'd2,
      MODE_ZIGZAG   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_SET  = 2'd1,
      CMD_LOOP = 2'd2,
      CMD_AB   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PB_NONE = 2'd0,
      PB_LOOP = 2'd1,
      PB_AB   = 2'd2
   } pb_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [1:0] ch;
      pb_type     pb;
   } result_type;

   typedef struct packed {
      result_type [MAX_RESULTS-1:0] slot;
      logic [1:0]                   last_idx;
      logic                         block_front;
   } record_type;

   function automatic result_type mk_none();
      result_type r;
      r.cmd = CMD_NONE;
      r.ch  = 2'd0;
      r.pb  = PB_NONE;
      return r;
   endfunction

   function automatic result_type mk_set(input logic [1:0] ch);
      result_type r;
      r.cmd = CMD_SET;
      r.ch  = ch;
      r.pb  = PB_NONE;
      return r;
   endfunction

   function automatic result_type mk_loop(input logic prog);
      result_type r;
      r.cmd = CMD_LOOP;
      r.ch  = 2'd0;
      r.pb  = prog ? PB_LOOP : PB_NONE;
      return r;
   endfunction

   function automatic result_type mk_ab(input logic prog);
      result_type r;
      r.cmd = CMD_AB;
      r.ch  = 2'd0;
      r.pb  = prog ? PB_AB : PB_NONE;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- sv/fsd_front.sv -----
// Front end: configuration registers, contact edge detection, lockout and
// zigzag state; turns one poll tick into a tick record. Uses fsd_pkg.
`default_nettype none

module fsd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [7:0]         csr_wdata,
   input  wire logic               accept,
   input  wire logic [5:0]         contacts,
   input  wire logic [1:0]         amp_channel,
   input  wire logic               prog_mode,
   output fsd_pkg::record_type     rec
);

   fsd_pkg::mode_type mode_ff;
   logic [7:0]        guard_ticks_ff;
   logic [5:0]        prev_ff;
   logic              primed_ff;
   logic [7:0]        guard_ff;
   logic [1:0]        zl_ff, zl_in;
   logic [1:0]        zh_ff, zh_in;

   logic [5:0]             diff;
   logic                   t1, s1, t2, s2, act;
   fsd_pkg::result_type    a0, a1, b0, b1;
   logic [1:0]             a_n, b_n;
   logic [2:0]             total;
   logic [1:0]             cur1, want1, want2, rch;
   logic                   g1, g2;

   assign diff = contacts ^ prev_ff;
   assign t1   = diff[1];
   assign s1   = diff[2];
   assign t2   = diff[4];
   assign s2   = diff[5];
   assign act  = primed_ff && (guard_ff == 8'd0);

   always_comb begin
      a0    = fsd_pkg::mk_none();
      a1    = fsd_pkg::mk_none();
      a_n   = 2'd0;
      cur1  = amp_channel;
      zl_in = zl_ff;
      zh_in = zh_ff;
      g1    = 1'b0;
      want1 = t1 ? 2'd0 : 2'd1;
      rch   = {~contacts[2], ~contacts[1]};
      if (act && contacts[0]) begin
         case (mode_ff)
            fsd_pkg::MODE_DISCRETE: begin
               if (t1 || s1) begin
                  a_n = 2'd1;
                  if (amp_channel != want1) begin
                     a0   = fsd_pkg::mk_set(want1);
                     cur1 = want1;
                  end else begin
                     a0 = fsd_pkg::mk_loop(prog_mode);
                  end
               end
            end
            fsd_pkg::MODE_RELAY: begin
               if ((t1 || s1) && (amp_channel != rch)) begin
                  a0  = fsd_pkg::mk_set(rch);
                  a_n = 2'd1;
               end
            end
            fsd_pkg::MODE_RING: begin
               g1 = t1 || s1;
               if (t1 && s1) begin
                  a0  = fsd_pkg::mk_set(amp_channel - 2'd1);
                  a1  = fsd_pkg::mk_set(amp_channel + 2'd1);
                  a_n = 2'd2;
               end else if (t1) begin
                  a0  = fsd_pkg::mk_set(amp_channel - 2'd1);
                  a_n = 2'd1;
               end else if (s1) begin
                  a0  = fsd_pkg::mk_set(amp_channel + 2'd1);
                  a_n = 2'd1;
               end
            end
            default: begin
               g1 = t1 || s1;
               if (t1 && (amp_channel < 2'd2)) begin
                  zl_in = (amp_channel == 2'd0) ? 2'd1 : 2'd0;
               end
               if (s1 && (amp_channel > 2'd1)) begin
                  zh_in = (amp_channel == 2'd2) ? 2'd3 : 2'd2;
               end
               if (t1 && s1) begin
                  a0  = fsd_pkg::mk_set(zl_in);
                  a1  = fsd_pkg::mk_set(zh_in);
                  a_n = 2'd2;
               end else if (t1) begin
                  a0  = fsd_pkg::mk_set(zl_in);
                  a_n = 2'd1;
               end else if (s1) begin
                  a0  = fsd_pkg::mk_set(zh_in);
                  a_n = 2'd1;
               end
            end
         endcase
      end
   end

   always_comb begin
      b0    = fsd_pkg::mk_none();
      b1    = fsd_pkg::mk_none();
      b_n   = 2'd0;
      g2    = 1'b0;
      want2 = t2 ? 2'd2 : 2'd3;
      if (act && contacts[3]) begin
         if (mode_ff == fsd_pkg::MODE_DISCRETE) begin
            if (t2 || s2) begin
               b_n = 2'd1;
               b0  = (cur1 != want2) ? fsd_pkg::mk_set(want2) : fsd_pkg::mk_loop(prog_mode);
            end
         end else begin
            g2 = t2 || s2;
            if (s2 && t2) begin
               b0  = fsd_pkg::mk_loop(prog_mode);
               b1  = fsd_pkg::mk_ab(prog_mode);
               b_n = 2'd2;
            end else if (s2) begin
               b0  = fsd_pkg::mk_loop(prog_mode);
               b_n = 2'd1;
            end else if (t2) begin
               b0  = fsd_pkg::mk_ab(prog_mode);
               b_n = 2'd1;
            end
         end
      end
   end

   always_comb begin
      rec.slot[0] = a0;
      rec.slot[1] = a1;
      rec.slot[2] = fsd_pkg::mk_none();
      rec.slot[3] = fsd_pkg::mk_none();
      case (a_n)
         2'd0: begin
            rec.slot[0] = b0;
            rec.slot[1] = b1;
         end
         2'd1: begin
            rec.slot[1] = b0;
            rec.slot[2] = b1;
         end
         default: begin
            rec.slot[2] = b0;
            rec.slot[3] = b1;
         end
      endcase
      total            = {1'b0, a_n} + {1'b0, b_n};
      rec.last_idx     = (total == 3'd0) ? 2'd0 : 2'(total - 3'd1);
      rec.block_front  = (mode_ff == fsd_pkg::MODE_RELAY) && contacts[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= fsd_pkg::MODE_DISCRETE;
         guard_ticks_ff <= fsd_pkg::GUARD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            fsd_pkg::CSR_SWITCH_MODE: mode_ff        <= fsd_pkg::mode_type'(csr_wdata[1:0]);
            default:                  guard_ticks_ff <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= 6'd0;
         primed_ff <= 1'b0;
         guard_ff  <= 8'd0;
         zl_ff     <= 2'd0;
         zh_ff     <= fsd_pkg::ZIG_HIGH_RESET;
      end else if (accept) begin
         prev_ff <= contacts;
         zl_ff   <= zl_in;
         zh_ff   <= zh_in;
         if (!primed_ff) begin
            primed_ff <= 1'b1;
         end else if (guard_ff != 8'd0) begin
            guard_ff <= guard_ff - 8'd1;
         end else if (g1 || g2) begin
            guard_ff <= guard_ticks_ff;
         end
      end
   end

   a_guard_primed: assert property (@(posedge clock) disable iff (reset)
      (guard_ff != 8'd0) |-> primed_ff)
      else $error("lockout running before first tick");

endmodule

`default_nettype wire

// ----- sv/fsd_queue.sv -----
// Tick-record queue between the front end and the result sequencer.
// Register file with read and write pointers. Uses fsd_pkg.
`default_nettype none

module fsd_queue #(
   parameter int DEPTH = fsd_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire fsd_pkg::record_type wr_data,
   input  wire logic                rd_en,
   output fsd_pkg::record_type      rd_data,
   output logic                     full,
   output logic                     empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   fsd_pkg::record_type mem_ff [DEPTH];
   logic [PW-1:0] wp_ff, rp_ff;
   logic [CW-1:0] cnt_ff;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rp_ff];

   function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) begin
            wp_ff <= nxt(wp_ff);
         end
         if (rd_en) begin
            rp_ff <= nxt(rp_ff);
         end
         if (wr_en && !rd_en) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (rd_en && !wr_en) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !wr_en)
      else $error("write into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !rd_en)
      else $error("read from empty queue");

endmodule

`default_nettype wire

// ----- sv/fsd_back.sv -----
// Back end: walks the head tick record one result per cycle into the
// result register while each result is popped. Uses fsd_pkg.
`default_nettype none

module fsd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fsd_pkg::record_type head,
   input  wire logic                head_empty,
   output logic                     head_pop,
   input  wire logic                pop,
   output logic                     empty,
   output fsd_pkg::result_type      res,
   output logic                     res_block_front,
   output logic                     res_last
);

   logic [1:0]          k_ff;
   logic                valid_ff;
   fsd_pkg::result_type res_ff;
   logic                bf_ff, last_ff;
   logic                load, is_last;

   assign load     = !head_empty && (!valid_ff || pop);
   assign is_last  = (k_ff == head.last_idx);
   assign head_pop = load && is_last;

   assign empty           = !valid_ff;
   assign res             = res_ff;
   assign res_block_front = bf_ff;
   assign res_last        = last_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= head.slot[k_ff];
         bf_ff   <= head.block_front;
         last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         k_ff     <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            k_ff     <= is_last ? 2'd0 : k_ff + 2'd1;
         end else if (pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   a_index_in_record: assert property (@(posedge clock) disable iff (reset)
      !head_empty |-> (k_ff <= head.last_idx))
      else $error("result index past end of record");

   a_record_end: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> (k_ff == 2'd0) && last_ff)
      else $error("record retired without last result");

endmodule

`default_nettype wire

// ----- sv/footswitch_channel_decoder.sv -----
// Footswitch channel decoder top level: front end, tick-record queue, back end.
// An accepted tick is written into the queue, then its first result into the result register.
// Throughput: one tick per cycle in while the queue has room, one result per cycle out while
// pop is held; a tick yields 1 to 4 results and the queue holds QDEPTH ticks.
// Reset: synchronous, active high; mode discrete, guard 50, queue and result empty.
`default_nettype none

module footswitch_channel_decoder #(
   parameter int QDEPTH = fsd_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata,
   input  wire logic       push,
   output logic            full,
   input  wire logic       req_sw1_present,
   input  wire logic       req_sw1_tip,
   input  wire logic       req_sw1_sleeve,
   input  wire logic       req_sw2_present,
   input  wire logic       req_sw2_tip,
   input  wire logic       req_sw2_sleeve,
   input  wire logic [1:0] req_amp_channel,
   input  wire logic       req_prog_mode,
   output logic            empty,
   input  wire logic       pop,
   output logic [1:0]      rsp_command,
   output logic [1:0]      rsp_channel,
   output logic [1:0]      rsp_prog_button,
   output logic            rsp_block_front,
   output logic            rsp_last
);

   fsd_pkg::record_type front_rec, head_rec;
   fsd_pkg::result_type res;
   logic                accept, q_empty, head_pop;

   assign accept = push && !full;

   fsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .contacts    ({req_sw2_sleeve, req_sw2_tip, req_sw2_present,
                     req_sw1_sleeve, req_sw1_tip, req_sw1_present}),
      .amp_channel (req_amp_channel),
      .prog_mode   (req_prog_mode),
      .rec         (front_rec)
   );

   fsd_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (front_rec),
      .rd_en   (head_pop),
      .rd_data (head_rec),
      .full    (full),
      .empty   (q_empty)
   );

   fsd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head_rec),
      .head_empty      (q_empty),
      .head_pop        (head_pop),
      .pop             (pop),
      .empty           (empty),
      .res             (res),
      .res_block_front (rsp_block_front),
      .res_last        (rsp_last)
   );

   assign rsp_command     = res.cmd;
   assign rsp_channel     = res.ch;
   assign rsp_prog_button = res.pb;

endmodule

`default_nettype wire
